// ===== rtl/core/crmp_pkg.sv =====
// Shared types and constants for the 3x3 conv / ReLU / 2x2 max pool stream.
// No dependencies; imported by crmp_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package crmp_pkg;

    localparam int PIX_W        = 8;
    localparam int KERNEL_SIZE  = 3;
    localparam int COEF_W       = 8;
    localparam int PROD1_W      = 17;
    localparam int DOT_W        = 19;
    localparam int SUM_W        = 20;
    localparam int SCALE_W      = 24;
    localparam int BIAS_W       = 16;
    localparam int PROD_W       = 44;
    localparam int FRAC_BITS    = 16;
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 16;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_MAX      = 255;

    localparam logic [WIDTH_W-1:0]    RST_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_W-1:0]   RST_HEIGHT = 16'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_TOP = 24'd0;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_MID = 24'd65536;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_BOT = 24'd0;
    localparam logic [SCALE_W-1:0]    RST_SCALE  = 24'd65536;
    localparam logic [BIAS_W-1:0]     RST_BIAS   = 16'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEFF_TOP    = 3'd2,
        CFG_COEFF_MID    = 3'd3,
        CFG_COEFF_BOT    = 3'd4,
        CFG_SCALE        = 3'd5,
        CFG_BIAS         = 3'd6
    } cfg_reg_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NEXT,
        ST_DOT,
        ST_SCALE,
        ST_CLAMP,
        ST_POOL
    } fsm_state_t;

    // pending conv centers, processed in this order
    localparam int JOB_A = 0;  // (x-1, y-1)
    localparam int JOB_C = 1;  // (x-1, y), bottom row
    localparam int JOB_B = 2;  // (w-1, y-1), right column
    localparam int JOB_D = 3;  // (w-1, y), bottom right
    localparam int JOB_N = 4;

    typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0]  pix_col_t;
    typedef logic [KERNEL_SIZE-1:0][COEF_W-1:0] coef_col_t;

    typedef struct packed {
        logic shift;
        logic up;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/crmp_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/crmp_cell.sv =====
// One window column cell: holds three pixels, registers its column dot product
// and adds it onto the running sum from its left neighbor. Uses crmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crmp_cell
    import crmp_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cell_ctrl_t              ctrl,
    input  wire pix_col_t                col_in,
    input  wire coef_col_t               coef,
    input  wire logic signed [SUM_W-1:0] psum_in,
    output pix_col_t                     col_out,
    output logic signed [SUM_W-1:0]      psum_out
);

    pix_col_t                   col_reg;
    pix_col_t                   taps;
    logic signed [PROD1_W-1:0]  prod [KERNEL_SIZE];
    logic signed [DOT_W-1:0]    dot_next;
    logic signed [DOT_W-1:0]    dot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (ctrl.shift) begin
            col_reg <= col_in;
        end
    end

    // up mode: rows move up one, bottom row padded with zero
    always_comb begin
        if (ctrl.up) begin
            taps[0] = col_reg[1];
            taps[1] = col_reg[2];
            taps[2] = '0;
        end else begin
            taps = col_reg;
        end
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            prod[r] = PROD1_W'($signed({1'b0, taps[r]}) * $signed(coef[r]));
        end
        dot_next = DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]);
    end

    always_ff @(posedge aclk) begin
        dot_reg <= dot_next;
    end

    assign col_out  = col_reg;
    assign psum_out = psum_in + SUM_W'(dot_reg);

endmodule

`default_nettype wire

// ===== rtl/core/conv3x3_relu_maxpool2x2_stream.sv =====
// Each accepted pixel is written to the line stores and shifted into the window; then every
// pending conv center is computed in turn through the dot, scale, clamp and pool states, a
// center on an odd trailing row or column is dropped, and a zero column is shifted in at a
// row end. An output stall holds the pool state. A new pixel is accepted only once all
// centers of the last one are done (shared scale multiplier, pool memory RMW).
// Reset (aresetn, synchronous): clears counters, window, control, output valid and config.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_relu_maxpool2x2_stream
    import crmp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] pixel_in
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] pooled_pixel
    output logic                       m_tlast    // frame_last
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PD = (MAX_WIDTH + 1) / 2;

    // configuration
    logic [WIDTH_W-1:0]    cfg_width_reg;
    logic [HEIGHT_W-1:0]   cfg_height_reg;
    logic [CFG_DATA_W-1:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [BIAS_W-1:0]     bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= RST_WIDTH;
            cfg_height_reg <= RST_HEIGHT;
            coef_top_reg   <= RST_COEF_TOP;
            coef_mid_reg   <= RST_COEF_MID;
            coef_bot_reg   <= RST_COEF_BOT;
            scale_reg      <= RST_SCALE;
            bias_reg       <= RST_BIAS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_wr_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                CFG_COEFF_TOP:    coef_top_reg   <= cfg_wr_data;
                CFG_COEFF_MID:    coef_mid_reg   <= cfg_wr_data;
                CFG_COEFF_BOT:    coef_bot_reg   <= cfg_wr_data;
                CFG_SCALE:        scale_reg      <= cfg_wr_data[SCALE_W-1:0];
                CFG_BIAS:         bias_reg       <= cfg_wr_data[BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [WW-1:0]       w_last_full;
    logic [XW-1:0]       w_last, wp_last;
    logic [HEIGHT_W-1:0] h_last, hp_last;

    always_comb begin
        if (cfg_width_reg < 11'd2) begin
            w_eff = WW'(2);
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg_width_reg);
        end
        h_eff       = (cfg_height_reg < 16'd2) ? 16'd2 : cfg_height_reg;
        w_last_full = w_eff - 1'b1;
        w_last      = w_last_full[XW-1:0];
        wp_last     = XW'({w_eff[WW-1:1], 1'b0} - 1'b1);
        h_last      = h_eff - 1'b1;
        hp_last     = {h_eff[HEIGHT_W-1:1], 1'b0} - 1'b1;
    end

    // control
    fsm_state_t          state_reg, state_next;
    logic [XW-1:0]       col_cnt_reg, x_comb, x_reg;
    logic [HEIGHT_W-1:0] row_cnt_reg, y_comb, y_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic [JOB_N-1:0]    pend_reg, pend_next;
    logic                zshift_reg, zshift_next;
    logic [XW-1:0]       cx_reg, cx_next;
    logic [HEIGHT_W-1:0] cy_reg, cy_next;
    logic                up_reg, up_next;
    logic                in_beat;
    logic                shift_en, clear_win, zero_col;
    logic                line_we, pool_we, out_load;

    assign x_comb  = (col_cnt_reg > w_last) ? w_last : col_cnt_reg;
    assign y_comb  = (row_cnt_reg > h_last) ? h_last : row_cnt_reg;
    assign in_beat = s_tvalid && s_tready;

    // pool evaluation
    logic [PIX_W-1:0] relu_reg;
    logic [PIX_W-1:0] pool_rd;
    logic [PIX_W-1:0] pool_new;
    logic             pool_init, pool_out, pool_last, slot_free;

    assign pool_init = !cx_reg[0] && !cy_reg[0];
    assign pool_out  = cx_reg[0] && cy_reg[0];
    assign pool_last = (cx_reg == wp_last) && (cy_reg == hp_last);
    assign pool_new  = (pool_init || relu_reg > pool_rd) ? relu_reg : pool_rd;
    assign slot_free = !m_tvalid || m_tready;

    always_comb begin
        logic [XW-1:0]       job_cx;
        logic [HEIGHT_W-1:0] job_cy;
        logic                job_up, take;
        job_cx      = x_reg;
        job_cy      = y_reg;
        job_up      = 1'b0;
        take        = 1'b0;
        state_next  = state_reg;
        pend_next   = pend_reg;
        zshift_next = zshift_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        up_next     = up_reg;
        s_tready    = 1'b0;
        shift_en    = 1'b0;
        clear_win   = 1'b0;
        zero_col    = 1'b0;
        line_we     = 1'b0;
        pool_we     = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                line_we     = 1'b1;
                shift_en    = 1'b1;
                clear_win   = (x_reg == '0);
                zshift_next = 1'b0;
                pend_next[JOB_A] = (y_reg != '0) && (x_reg != '0);
                pend_next[JOB_C] = (y_reg == h_last) && (x_reg != '0);
                pend_next[JOB_B] = (y_reg != '0) && (x_reg == w_last);
                pend_next[JOB_D] = (y_reg == h_last) && (x_reg == w_last);
                state_next  = ST_NEXT;
            end
            ST_NEXT: begin
                priority if (pend_reg[JOB_A]) begin
                    job_cx = x_reg - 1'b1;
                    job_cy = y_reg - 1'b1;
                    take   = 1'b1;
                    pend_next[JOB_A] = 1'b0;
                end else if (pend_reg[JOB_C]) begin
                    job_cx = x_reg - 1'b1;
                    job_up = 1'b1;
                    take   = 1'b1;
                    pend_next[JOB_C] = 1'b0;
                end else if ((pend_reg[JOB_B] || pend_reg[JOB_D]) && !zshift_reg) begin
                    shift_en    = 1'b1;
                    zero_col    = 1'b1;
                    zshift_next = 1'b1;
                end else if (pend_reg[JOB_B]) begin
                    job_cy = y_reg - 1'b1;
                    take   = 1'b1;
                    pend_next[JOB_B] = 1'b0;
                end else if (pend_reg[JOB_D]) begin
                    job_up = 1'b1;
                    take   = 1'b1;
                    pend_next[JOB_D] = 1'b0;
                end else begin
                    state_next = ST_IDLE;
                end
                if (take && job_cx <= wp_last && job_cy <= hp_last) begin
                    cx_next    = job_cx;
                    cy_next    = job_cy;
                    up_next    = job_up;
                    state_next = ST_DOT;
                end
            end
            ST_DOT:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_POOL;
            ST_POOL: begin
                if (!pool_out || slot_free) begin
                    pool_we    = 1'b1;
                    out_load   = pool_out;
                    state_next = ST_NEXT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            pend_reg    <= '0;
            zshift_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            zshift_reg <= zshift_next;
            if (in_beat) begin
                if (x_comb == w_last) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= (y_comb == h_last) ? '0 : y_comb + 1'b1;
                end else begin
                    col_cnt_reg <= x_comb + 1'b1;
                    row_cnt_reg <= y_comb;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            pix_reg <= s_tdata;
            x_reg   <= x_comb;
            y_reg   <= y_comb;
        end
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        up_reg <= up_next;
    end

    // line stores
    logic [PIX_W-1:0] older_rd, newer_rd;

    crmp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_older (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (x_reg),
        .wr_data (newer_rd),
        .rd_addr (x_comb),
        .rd_data (older_rd)
    );

    crmp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_newer (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (x_reg),
        .wr_data (pix_reg),
        .rd_addr (x_comb),
        .rd_data (newer_rd)
    );

    // window: chain of column cells, left to right
    pix_col_t                new_col;
    pix_col_t                cell_in  [KERNEL_SIZE];
    pix_col_t                cell_out [KERNEL_SIZE];
    logic signed [SUM_W-1:0] psum     [KERNEL_SIZE+1];
    cell_ctrl_t              cell_ctrl;

    assign new_col[0] = (y_reg >= 16'd2) ? older_rd : '0;
    assign new_col[1] = (y_reg != '0) ? newer_rd : '0;
    assign new_col[2] = pix_reg;
    assign cell_ctrl  = '{shift: shift_en, up: up_reg};
    assign psum[0]    = '0;

    for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_cell
        coef_col_t coef;
        assign coef[0] = coef_top_reg[COEF_W*k +: COEF_W];
        assign coef[1] = coef_mid_reg[COEF_W*k +: COEF_W];
        assign coef[2] = coef_bot_reg[COEF_W*k +: COEF_W];
        if (k == KERNEL_SIZE - 1) begin : g_head
            assign cell_in[k] = zero_col ? '0 : new_col;
        end else begin : g_body
            assign cell_in[k] = clear_win ? '0 : cell_out[k+1];
        end
        crmp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .col_in   (cell_in[k]),
            .coef     (coef),
            .psum_in  (psum[k]),
            .col_out  (cell_out[k]),
            .psum_out (psum[k+1])
        );
    end

    // scale, truncate toward zero, bias, clamp
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] trunc_q, biased_q;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCALE) begin
            prod_reg <= PROD_W'(psum[KERNEL_SIZE]) * PROD_W'($signed(scale_reg));
        end
    end

    always_comb begin
        trunc_q  = prod_reg[PROD_W-1]
                 ? (prod_reg + PROD_W'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS
                 : prod_reg >>> FRAC_BITS;
        biased_q = trunc_q + PROD_W'($signed(bias_reg));
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLAMP) begin
            if (biased_q < 0) begin
                relu_reg <= '0;
            end else if (biased_q > PROD_W'(PIX_MAX)) begin
                relu_reg <= PIX_W'(PIX_MAX);
            end else begin
                relu_reg <= biased_q[PIX_W-1:0];
            end
        end
    end

    // pool partial maxima
    crmp_ram #(.WIDTH(PIX_W), .DEPTH(PD)) u_pool (
        .aclk    (aclk),
        .wr_en   (pool_we),
        .wr_addr (cx_reg[XW-1:1]),
        .wr_data (pool_new),
        .rd_addr (cx_reg[XW-1:1]),
        .rd_data (pool_rd)
    );

    // output register
    logic             m_tvalid_reg;
    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= pool_new;
            m_tlast_reg <= pool_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crmp_checker.sv =====
// Port-level checks for conv3x3_relu_maxpool2x2_stream, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none

module crmp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous pixel in work");

    a_out_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("output beat appeared with no pixel in work");

endmodule

bind conv3x3_relu_maxpool2x2_stream crmp_checker u_crmp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
